FILE: sv/pca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types, register codes and arithmetic constants of the pixel colour
// adjustment pipeline.
// ----------------------------------------------------------------------------
package pca_pkg;

  // Pipeline shape: adjustment stages in the top level, filter stages after.
  localparam int ADJ_STAGES  = 7;
  localparam int FILT_STAGES = 6;
  localparam int NUM_STAGES  = ADJ_STAGES + FILT_STAGES;

  // Configuration port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CONTRAST    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TEMPERATURE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RED_GAIN    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GREEN_GAIN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BLUE_GAIN   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE = 3'd6;

  // Preset filter codes; the two spare codes pass the pixel unchanged.
  typedef enum logic [2:0] {
    FILT_NONE     = 3'd0,
    FILT_GRAY     = 3'd1,
    FILT_SEPIA    = 3'd2,
    FILT_NEGATIVE = 3'd3,
    FILT_PASTEL   = 3'd4,
    FILT_VINTAGE  = 3'd5
  } filter_mode_t;

  // Settings saturate to this magnitude.
  localparam logic signed [7:0] SETTING_MAX_S = 8'sd100;
  localparam int                SETTING_MAX   = 100;

  // Contrast factor table, one entry per setting, unsigned Q2.16.
  localparam int     CONTRAST_LUT_DEPTH = 2 * SETTING_MAX + 1;
  localparam int     CONTRAST_F_W       = 18;
  localparam int     CONTRAST_FRAC      = 16;
  localparam longint CONTRAST_K         = 259;
  localparam longint Q16_ONE            = 65536;
  localparam logic [CONTRAST_F_W-1:0] CONTRAST_UNITY = 18'd65536;

  // Division by constants through reciprocal multiplication.
  localparam int TEMP_DIV10_MUL   = 205;
  localparam int TEMP_DIV10_SHIFT = 11;
  localparam int DIV10_MUL        = 52429;
  localparam int DIV10_SHIFT      = 19;
  localparam int DIV3_MUL         = 2731;
  localparam int DIV3_SHIFT       = 13;
  localparam int DIV100_MUL       = 655;
  localparam int DIV100_SHIFT     = 16;
  localparam int DIV1000_MUL      = 1048;
  localparam int DIV1000_SHIFT    = 20;

  localparam int NUM_CH = 3;

  // Filter coefficients, rows are red, green, blue outputs.
  localparam logic [4:0] GRAY_COEF [NUM_CH] = '{5'd11, 5'd16, 5'd5};
  localparam int         GRAY_SHIFT = 5;
  localparam logic [9:0] SEPIA_COEF [NUM_CH][NUM_CH] = '{
    '{10'd393, 10'd769, 10'd189},
    '{10'd349, 10'd686, 10'd168},
    '{10'd272, 10'd534, 10'd131}
  };
  localparam logic [3:0] PASTEL_MUL [NUM_CH] = '{4'd8, 4'd8, 4'd9};
  localparam logic [9:0] PASTEL_ADD [NUM_CH] = '{10'd700, 10'd600, 10'd950};
  localparam logic [3:0] VINT_COEF [NUM_CH][NUM_CH] = '{
    '{4'd9, 4'd5, 4'd2},
    '{4'd3, 4'd7, 4'd2},
    '{4'd1, 4'd3, 4'd6}
  };

  typedef logic [NUM_CH-1:0][7:0] rgb_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pixel_out_t;

  // Settings as the datapath uses them.
  typedef struct packed {
    logic signed [7:0]         brightness;
    logic [CONTRAST_F_W-1:0]   contrast_f;
    logic signed [5:0]         temp_red;
    logic signed [5:0]         temp_blue;
    logic [NUM_CH-1:0][7:0]    gain_mult;
    logic [2:0]                filter_mode;
  } cfg_t;

  // Saturate a raw 8-bit setting to -100..100.
  function automatic logic signed [7:0] sat_setting(input logic [7:0] raw);
    logic signed [7:0] s;
    s = signed'(raw);
    if (s > SETTING_MAX_S) begin
      s = SETTING_MAX_S;
    end else if (s < -SETTING_MAX_S) begin
      s = -SETTING_MAX_S;
    end
    return s;
  endfunction

  // Clamp a signed intermediate to one 8-bit channel.
  function automatic logic [7:0] clamp_u8(input logic signed [11:0] v);
    logic [7:0] res;
    if (v < 12'sd0) begin
      res = 8'd0;
    end else if (v > 12'sd255) begin
      res = 8'hFF;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: sv/pca_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pca_cfg
// Setting registers behind the APB-style port. Each signed setting is saturated
// on write, and the contrast factor is looked up and the temperature offsets worked out then.
// ----------------------------------------------------------------------------
module pca_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pca_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pca_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pca_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output pca_pkg::cfg_t                   cfg
);
  import pca_pkg::*;

  logic                     wr_en;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic signed [7:0]        wr_sat;
  logic signed [8:0]        lut_idx_s;
  logic [CONTRAST_F_W-1:0]  contrast_lut [CONTRAST_LUT_DEPTH];
  logic [6:0]               temp_abs;
  logic [8:0]               temp_mag;
  logic [4:0]               temp_fl;
  logic [4:0]               temp_cl;
  logic signed [5:0]        temp_red_nxt;
  logic signed [5:0]        temp_blue_nxt;

  logic signed [7:0]        brightness_r;
  logic signed [7:0]        contrast_r;
  logic signed [7:0]        temperature_r;
  logic signed [7:0]        gain_r [NUM_CH];
  logic [2:0]               filter_mode_r;
  logic [CONTRAST_F_W-1:0]  contrast_f_r;
  logic signed [5:0]        temp_red_r;
  logic signed [5:0]        temp_blue_r;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_sat  = sat_setting(pwdata[7:0]);

  // Contrast factor for every setting, worked out at elaboration.
  for (genvar k = 0; k < CONTRAST_LUT_DEPTH; k++) begin : g_contrast_lut
    localparam longint C = longint'(k) - longint'(SETTING_MAX);
    localparam longint F = (CONTRAST_K * (C + 255) * Q16_ONE) / (255 * (CONTRAST_K - C));
    assign contrast_lut[k] = CONTRAST_F_W'(F);
  end

  assign lut_idx_s = 9'(wr_sat) + 9'sd100;

  // Temperature offsets: floor(3t/10) for red and floor(-3t/10) for blue.
  assign temp_abs = 7'((wr_sat < 8'sd0) ? -wr_sat : wr_sat);
  assign temp_mag = 9'(temp_abs) * 9'd3;
  assign temp_fl  = 5'((17'(temp_mag) * 17'(TEMP_DIV10_MUL)) >> TEMP_DIV10_SHIFT);
  assign temp_cl  = 5'(((17'(temp_mag) + 17'd9) * 17'(TEMP_DIV10_MUL)) >> TEMP_DIV10_SHIFT);

  always_comb begin
    if (wr_sat < 8'sd0) begin
      temp_red_nxt  = -signed'(6'(temp_cl));
      temp_blue_nxt = signed'(6'(temp_fl));
    end else begin
      temp_red_nxt  = signed'(6'(temp_fl));
      temp_blue_nxt = -signed'(6'(temp_cl));
    end
  end

  // Register writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r  <= '0;
      contrast_r    <= '0;
      temperature_r <= '0;
      gain_r[0]     <= '0;
      gain_r[1]     <= '0;
      gain_r[2]     <= '0;
      filter_mode_r <= FILT_NONE;
      contrast_f_r  <= CONTRAST_UNITY;
      temp_red_r    <= '0;
      temp_blue_r   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BRIGHTNESS: begin
          brightness_r <= wr_sat;
        end
        REG_CONTRAST: begin
          contrast_r   <= wr_sat;
          contrast_f_r <= contrast_lut[lut_idx_s[7:0]];
        end
        REG_TEMPERATURE: begin
          temperature_r <= wr_sat;
          temp_red_r    <= temp_red_nxt;
          temp_blue_r   <= temp_blue_nxt;
        end
        REG_RED_GAIN: begin
          gain_r[0] <= wr_sat;
        end
        REG_GREEN_GAIN: begin
          gain_r[1] <= wr_sat;
        end
        REG_BLUE_GAIN: begin
          gain_r[2] <= wr_sat;
        end
        REG_FILTER_MODE: begin
          filter_mode_r <= pwdata[2:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read back the stored settings.
  always_comb begin
    unique case (reg_idx)
      REG_BRIGHTNESS:  prdata = APB_DATA_W'(brightness_r);
      REG_CONTRAST:    prdata = APB_DATA_W'(contrast_r);
      REG_TEMPERATURE: prdata = APB_DATA_W'(temperature_r);
      REG_RED_GAIN:    prdata = APB_DATA_W'(gain_r[0]);
      REG_GREEN_GAIN:  prdata = APB_DATA_W'(gain_r[1]);
      REG_BLUE_GAIN:   prdata = APB_DATA_W'(gain_r[2]);
      REG_FILTER_MODE: prdata = APB_DATA_W'(filter_mode_r);
      default:         prdata = '0;
    endcase
  end

  // Settings in the form the datapath uses; a gain becomes 100 + g.
  always_comb begin
    cfg.brightness  = brightness_r;
    cfg.contrast_f  = contrast_f_r;
    cfg.temp_red    = temp_red_r;
    cfg.temp_blue   = temp_blue_r;
    cfg.filter_mode = filter_mode_r;
    for (int i = 0; i < NUM_CH; i++) begin
      cfg.gain_mult[i] = 8'(9'(gain_r[i]) + 9'sd100);
    end
  end

endmodule
`default_nettype wire

FILE: sv/pca_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pca_filter
// Six-stage preset filter: gray, sepia, negative, pastel and vintage. The
// last stage is the output register of the block.
// ----------------------------------------------------------------------------
module pca_filter (
  input  logic                             clk,
  input  logic [pca_pkg::FILT_STAGES-1:0]  en,
  input  logic [2:0]                       filter_mode,
  input  pca_pkg::rgb_t                    px_in,
  output pca_pkg::rgb_t                    px_out
);
  import pca_pkg::*;

  // Stage f0: gray level, sepia and pastel sums.
  rgb_t        f0_px_r;
  logic [7:0]  f0_y_r,   f0_y_nxt;
  logic [12:0] y_sum;
  logic [18:0] f0_sep_r  [NUM_CH];
  logic [18:0] f0_sep_nxt [NUM_CH];
  logic [11:0] f0_past_r [NUM_CH];
  logic [11:0] f0_past_nxt [NUM_CH];

  always_comb begin
    y_sum = '0;
    for (int j = 0; j < NUM_CH; j++) begin
      y_sum = y_sum + 13'(px_in[j]) * 13'(GRAY_COEF[j]);
    end
    f0_y_nxt = 8'(y_sum >> GRAY_SHIFT);
    for (int i = 0; i < NUM_CH; i++) begin
      f0_sep_nxt[i] = '0;
      for (int j = 0; j < NUM_CH; j++) begin
        f0_sep_nxt[i] = f0_sep_nxt[i] + 19'(px_in[j]) * 19'(SEPIA_COEF[i][j]);
      end
      f0_past_nxt[i] = 12'(px_in[i]) * 12'(PASTEL_MUL[i]) + 12'(PASTEL_ADD[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      f0_px_r   <= px_in;
      f0_y_r    <= f0_y_nxt;
      f0_sep_r  <= f0_sep_nxt;
      f0_past_r <= f0_past_nxt;
    end
  end

  // Stage f1: reciprocal products for the divisions by 1000, 10 and 3.
  rgb_t        f1_px_r;
  logic [7:0]  f1_y_r;
  logic [18:0] f1_sep_r   [NUM_CH];
  logic [29:0] f1_sepm_r  [NUM_CH];
  logic [29:0] f1_sepm_nxt [NUM_CH];
  logic [27:0] f1_pastm_r [NUM_CH];
  logic [27:0] f1_pastm_nxt [NUM_CH];
  logic [21:0] f1_vtm_r   [NUM_CH];
  logic [21:0] f1_vtm_nxt [NUM_CH];
  logic [9:0]  vint_t     [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      f1_sepm_nxt[i]  = 30'(f0_sep_r[i]) * 30'(DIV1000_MUL);
      f1_pastm_nxt[i] = 28'(f0_past_r[i]) * 28'(DIV10_MUL);
      vint_t[i]       = 10'(f0_px_r[i]) + (10'(f0_y_r) << 1);
      f1_vtm_nxt[i]   = 22'(vint_t[i]) * 22'(DIV3_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      f1_px_r    <= f0_px_r;
      f1_y_r     <= f0_y_r;
      f1_sep_r   <= f0_sep_r;
      f1_sepm_r  <= f1_sepm_nxt;
      f1_pastm_r <= f1_pastm_nxt;
      f1_vtm_r   <= f1_vtm_nxt;
    end
  end

  // Stage f2: finish the quotients and pick every result but vintage.
  rgb_t        f2_res_r, f2_res_nxt;
  rgb_t        f2_d_r,   f2_d_nxt;
  rgb_t        sep_px;
  rgb_t        past_px;
  logic [9:0]  sep_q0  [NUM_CH];
  logic [9:0]  sep_q   [NUM_CH];
  logic [18:0] sep_rem [NUM_CH];
  logic [8:0]  past_q  [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sep_q0[i]  = 10'(f1_sepm_r[i] >> DIV1000_SHIFT);
      sep_rem[i] = f1_sep_r[i] - 19'(sep_q0[i]) * 19'd1000;
      sep_q[i]   = (sep_rem[i] >= 19'd1000) ? sep_q0[i] + 10'd1 : sep_q0[i];
      sep_px[i]  = (sep_q[i] > 10'd255) ? 8'hFF : sep_q[i][7:0];
      past_q[i]  = 9'(f1_pastm_r[i] >> DIV10_SHIFT);
      past_px[i] = (past_q[i] > 9'd255) ? 8'hFF : past_q[i][7:0];
      f2_d_nxt[i] = 8'(f1_vtm_r[i] >> DIV3_SHIFT);
    end
    case (filter_mode)
      FILT_GRAY:     f2_res_nxt = {f1_y_r, f1_y_r, f1_y_r};
      FILT_SEPIA:    f2_res_nxt = sep_px;
      FILT_NEGATIVE: f2_res_nxt = ~f1_px_r;
      FILT_PASTEL:   f2_res_nxt = past_px;
      default:       f2_res_nxt = f1_px_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      f2_res_r <= f2_res_nxt;
      f2_d_r   <= f2_d_nxt;
    end
  end

  // Stage f3: vintage colour mix.
  rgb_t        f3_res_r;
  logic [11:0] f3_n_r   [NUM_CH];
  logic [11:0] f3_n_nxt [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      f3_n_nxt[i] = '0;
      for (int j = 0; j < NUM_CH; j++) begin
        f3_n_nxt[i] = f3_n_nxt[i] + 12'(f2_d_r[j]) * 12'(VINT_COEF[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      f3_res_r <= f2_res_r;
      f3_n_r   <= f3_n_nxt;
    end
  end

  // Stage f4: reciprocal product for the vintage division by 10.
  rgb_t        f4_res_r;
  logic [27:0] f4_nm_r   [NUM_CH];
  logic [27:0] f4_nm_nxt [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      f4_nm_nxt[i] = 28'(f3_n_r[i]) * 28'(DIV10_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      f4_res_r <= f3_res_r;
      f4_nm_r  <= f4_nm_nxt;
    end
  end

  // Stage f5: vintage fade towards white and final selection.
  rgb_t       f5_px_r, f5_px_nxt;
  rgb_t       vint_px;
  logic [8:0] vint_q [NUM_CH];
  logic [7:0] vint_c [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      vint_q[i]  = 9'(f4_nm_r[i] >> DIV10_SHIFT);
      vint_c[i]  = (vint_q[i] > 9'd255) ? 8'hFF : vint_q[i][7:0];
      vint_px[i] = 8'((9'(vint_c[i]) + 9'd255) >> 1);
    end
    f5_px_nxt = (filter_mode == FILT_VINTAGE) ? vint_px : f4_res_r;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      f5_px_r <= f5_px_nxt;
    end
  end

  assign px_out = f5_px_r;

endmodule
`default_nettype wire

FILE: sv/pixel_color_adjust_pipeline.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_color_adjust_pipeline
// RGB pixel colour adjustment: brightness, contrast, temperature, channel
// gains and a preset filter, each channel clamped to 0..255.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock cycle unless all stages are full
// and the output is stalled, and returns one result item for each. Seven
// register stages do brightness, the contrast product and its rounding,
// temperature and the three-step gain division; six more run the preset
// filter, whose last stage is the output register. Each stage holds its own
// valid bit, so empty stages fill while the output waits and input is only
// refused once all 13 stages hold items. Settings are to be written over the
// APB port only while no item is in flight; the block does not enforce this.
// Each write but the filter mode one saturates to -100..100, and a contrast
// write looks its factor up from a 201-entry table at once, so an item may
// follow a write in the very next cycle. There is no start-up clearing pass.
// ----------------------------------------------------------------------------
module pixel_color_adjust_pipeline (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pca_pkg::pixel_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pca_pkg::pixel_out_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pca_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pca_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pca_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import pca_pkg::*;

  cfg_t                  cfg;
  logic [NUM_STAGES-1:0] vld_r, vld_nxt;
  logic [NUM_STAGES-1:0] en;
  rgb_t                  in_px;
  rgb_t                  out_px;

  pca_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A stage may load when it or any stage after it is empty, or the output
  // item is being taken.
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign en[k] = out_ready || !(&vld_r[NUM_STAGES-1:k]);
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  assign in_px[0] = in_data.in_red;
  assign in_px[1] = in_data.in_green;
  assign in_px[2] = in_data.in_blue;

  // Stage 0: brightness offset.
  rgb_t s0_px_r, s0_px_nxt;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      s0_px_nxt[i] = clamp_u8(signed'(12'(in_px[i])) + 12'($signed(cfg.brightness)));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_px_r <= s0_px_nxt;
    end
  end

  // Stage 1: contrast product around mid gray.
  logic signed [CONTRAST_F_W:0] contrast_fs;
  logic signed [8:0]            ctr_diff   [NUM_CH];
  logic signed [26:0]           s1_prod_r  [NUM_CH];
  logic signed [26:0]           s1_prod_nxt [NUM_CH];

  assign contrast_fs = signed'({1'b0, cfg.contrast_f});

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      ctr_diff[i]    = signed'(9'(s0_px_r[i])) - 9'sd128;
      s1_prod_nxt[i] = 27'(contrast_fs) * 27'(ctr_diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_prod_r <= s1_prod_nxt;
    end
  end

  // Stage 2: floor of the Q16 product, back to mid gray.
  rgb_t s2_px_r, s2_px_nxt;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      s2_px_nxt[i] = clamp_u8(12'(s1_prod_r[i] >>> CONTRAST_FRAC) + 12'sd128);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_px_r <= s2_px_nxt;
    end
  end

  // Stage 3: temperature shifts red and blue in opposite directions.
  rgb_t s3_px_r, s3_px_nxt;

  always_comb begin
    s3_px_nxt[0] = clamp_u8(signed'(12'(s2_px_r[0])) + 12'($signed(cfg.temp_red)));
    s3_px_nxt[1] = s2_px_r[1];
    s3_px_nxt[2] = clamp_u8(signed'(12'(s2_px_r[2])) + 12'($signed(cfg.temp_blue)));
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_px_r <= s3_px_nxt;
    end
  end

  // Stage 4: channel gain product p * (100 + g).
  logic [15:0] s4_prod_r   [NUM_CH];
  logic [15:0] s4_prod_nxt [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      s4_prod_nxt[i] = 16'(s3_px_r[i]) * 16'(cfg.gain_mult[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_prod_r <= s4_prod_nxt;
    end
  end

  // Stage 5: reciprocal estimate of the division by 100.
  logic [15:0] s5_x_r   [NUM_CH];
  logic [25:0] s5_y_r   [NUM_CH];
  logic [25:0] s5_y_nxt [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      s5_y_nxt[i] = 26'(s4_prod_r[i]) * 26'(DIV100_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_x_r <= s4_prod_r;
      s5_y_r <= s5_y_nxt;
    end
  end

  // Stage 6: the estimate is at most one short; correct it and clamp.
  rgb_t        s6_px_r, s6_px_nxt;
  logic [9:0]  gain_q0  [NUM_CH];
  logic [9:0]  gain_q   [NUM_CH];
  logic [16:0] gain_rem [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      gain_q0[i]  = 10'(s5_y_r[i] >> DIV100_SHIFT);
      gain_rem[i] = 17'(s5_x_r[i]) - 17'(gain_q0[i]) * 17'd100;
      gain_q[i]   = (gain_rem[i] >= 17'd100) ? gain_q0[i] + 10'd1 : gain_q0[i];
      s6_px_nxt[i] = (gain_q[i] > 10'd255) ? 8'hFF : gain_q[i][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_px_r <= s6_px_nxt;
    end
  end

  // Stages 7 to 12: preset filter and output register.
  pca_filter u_filter (
    .clk         (clk),
    .en          (en[NUM_STAGES-1:ADJ_STAGES]),
    .filter_mode (cfg.filter_mode),
    .px_in       (s6_px_r),
    .px_out      (out_px)
  );

  assign out_data.out_red   = out_px[0];
  assign out_data.out_green = out_px[1];
  assign out_data.out_blue  = out_px[2];

endmodule
`default_nettype wire

FILE: sv/pca_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pca_checker
// Port-level checks of the pixel colour adjustment pipeline, bound to the
// top level.
// ----------------------------------------------------------------------------
module pca_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input pca_pkg::pixel_out_t  out_data
);
  import pca_pkg::*;

  // Reset empties the pipeline, so no item is offered just after it.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item offered straight after reset");

  // While the output is taken, every stage can move, so input is never refused.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input refused although the output item is being taken");

  // Input is refused only when the pipeline is full and the output stalls.
  a_refuse_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused while the output is not stalled");

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result item dropped or changed");

endmodule

bind pixel_color_adjust_pipeline pca_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel colour adjustment pipeline. A directed
// table walks each adjustment and every filter, including saturated and
// unused settings. Random pixels then run under a series of register
// settings. An in-bench predictor supplies the expected colour of each
// pixel that has no value in the table, and both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb;
  import pca_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_PIXELS = 68;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [2:0] FILT_SPARE = 3'd6;

  // One row of the directed table: a register write or a pixel.
  typedef struct {
    bit                   is_write;
    logic [REG_IDX_W-1:0] idx;
    logic [31:0]          wdata;
    pixel_in_t            pix;
    bit                   typed;
    pixel_out_t           want;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pixel_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pixel_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // Settings as the pipeline should see them after saturation.
  longint set_brightness = 0;
  longint set_contrast = 0;
  longint set_temperature = 0;
  longint set_gain [3] = '{0, 0, 0};
  logic [2:0] set_filter = '0;

  pixel_out_t pix_expected [$];
  stim_row_t directed_rows [$];
  int fail_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_left = 0;

  pixel_color_adjust_pipeline u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Signed settings saturate to -100..100; only the low byte counts.
  function automatic longint sat_percent(input logic [7:0] raw);
    longint s;
    s = longint'(signed'(raw));
    if (s > 100) begin
      s = 100;
    end else if (s < -100) begin
      s = -100;
    end
    return s;
  endfunction

  function automatic longint clip_u8(input longint v);
    if (v < 0) begin
      return 0;
    end
    if (v > 255) begin
      return 255;
    end
    return v;
  endfunction

  // Expected colour of one pixel under the current settings.
  function automatic pixel_out_t predict_pixel(input pixel_in_t px);
    longint ch [3];
    longint d [3];
    longint n [3];
    longint fac;
    longint vr;
    longint vb;
    longint y;
    pixel_out_t res;
    ch[0] = px.in_red;
    ch[1] = px.in_green;
    ch[2] = px.in_blue;
    if (set_brightness != 0) begin
      for (int i = 0; i < 3; i++) ch[i] = clip_u8(ch[i] + set_brightness);
    end
    // Contrast factor in Q16, applied around mid grey with a floor shift.
    if (set_contrast != 0) begin
      fac = (longint'(259) * (set_contrast + 255) * 65536) / (255 * (259 - set_contrast));
      for (int i = 0; i < 3; i++) ch[i] = clip_u8(((fac * (ch[i] - 128)) >>> 16) + 128);
    end
    if (set_temperature != 0) begin
      vr = 10 * ch[0] + 3 * set_temperature;
      vb = 10 * ch[2] - 3 * set_temperature;
      ch[0] = (vr < 0) ? 0 : clip_u8(vr / 10);
      ch[2] = (vb < 0) ? 0 : clip_u8(vb / 10);
    end
    if (set_gain[0] != 0 || set_gain[1] != 0 || set_gain[2] != 0) begin
      for (int i = 0; i < 3; i++) ch[i] = clip_u8(ch[i] * (100 + set_gain[i]) / 100);
    end
    y = (11 * ch[0] + 16 * ch[1] + 5 * ch[2]) / 32;
    case (set_filter)
      FILT_GRAY: begin
        for (int i = 0; i < 3; i++) ch[i] = y;
      end
      FILT_SEPIA: begin
        d[0] = (393 * ch[0] + 769 * ch[1] + 189 * ch[2]) / 1000;
        d[1] = (349 * ch[0] + 686 * ch[1] + 168 * ch[2]) / 1000;
        d[2] = (272 * ch[0] + 534 * ch[1] + 131 * ch[2]) / 1000;
        for (int i = 0; i < 3; i++) ch[i] = clip_u8(d[i]);
      end
      FILT_NEGATIVE: begin
        for (int i = 0; i < 3; i++) ch[i] = 255 - ch[i];
      end
      FILT_PASTEL: begin
        ch[0] = clip_u8((8 * ch[0] + 700) / 10);
        ch[1] = clip_u8((8 * ch[1] + 600) / 10);
        ch[2] = clip_u8((9 * ch[2] + 950) / 10);
      end
      FILT_VINTAGE: begin
        for (int i = 0; i < 3; i++) d[i] = (ch[i] + 2 * y) / 3;
        n[0] = clip_u8((9 * d[0] + 5 * d[1] + 2 * d[2]) / 10);
        n[1] = clip_u8((3 * d[0] + 7 * d[1] + 2 * d[2]) / 10);
        n[2] = clip_u8((d[0] + 3 * d[1] + 6 * d[2]) / 10);
        for (int i = 0; i < 3; i++) ch[i] = (n[i] + 255) / 2;
      end
      default: begin
      end
    endcase
    res.out_red = 8'(clip_u8(ch[0]));
    res.out_green = 8'(clip_u8(ch[1]));
    res.out_blue = 8'(clip_u8(ch[2]));
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_channel(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Table builders for the directed part.
  task automatic add_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    stim_row_t row;
    row = '{1'b1, idx, data, '0, 1'b0, '0};
    directed_rows.push_back(row);
  endtask

  task automatic add_pixel(input int r, input int g, input int b);
    stim_row_t row;
    row = '{1'b0, '0, '0, {8'(r), 8'(g), 8'(b)}, 1'b0, '0};
    directed_rows.push_back(row);
  endtask

  task automatic add_known(input int r, input int g, input int b,
                           input int er, input int eg, input int eb);
    stim_row_t row;
    row = '{1'b0, '0, '0, {8'(r), 8'(g), 8'(b)}, 1'b1, {8'(er), 8'(eg), 8'(eb)}};
    directed_rows.push_back(row);
  endtask

  // Offer one pixel, with an occasional gap first, and log its expectation.
  task automatic send_pixel(input pixel_in_t px, input bit typed, input pixel_out_t want);
    if (idle_pct != 0 && $urandom_range(0, 199) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pix_expected.push_back(typed ? want : predict_pixel(px));
  endtask

  // Stop offering pixels and let every expected result come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pix_expected.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Register write in a setup and an access phase, then idle; the predictor's copy follows it.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BRIGHTNESS: set_brightness = sat_percent(data[7:0]);
      REG_CONTRAST: set_contrast = sat_percent(data[7:0]);
      REG_TEMPERATURE: set_temperature = sat_percent(data[7:0]);
      REG_RED_GAIN: set_gain[0] = sat_percent(data[7:0]);
      REG_GREEN_GAIN: set_gain[1] = sat_percent(data[7:0]);
      REG_BLUE_GAIN: set_gain[2] = sat_percent(data[7:0]);
      REG_FILTER_MODE: set_filter = data[2:0];
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // Random register value; phases 0 and 1 pin the signed ones to the extremes.
  function automatic logic [31:0] pick_setting(input int ph, input logic [REG_IDX_W-1:0] idx);
    logic [7:0] lo;
    logic [31:0] junk;
    junk = $urandom;
    if (idx == REG_FILTER_MODE) begin
      lo = 8'($urandom_range(0, 255));
    end else if (ph == 0) begin
      lo = ($urandom_range(0, 1) != 0) ? 8'd100 : 8'd127;
    end else if (ph == 1) begin
      lo = ($urandom_range(0, 1) != 0) ? 8'h9C : 8'h80;
    end else begin
      case ($urandom_range(0, 9))
        0: lo = 8'd0;
        1: lo = 8'd100;
        2: lo = 8'h9C;
        3: lo = 8'($urandom_range(0, 255));
        default: lo = 8'($urandom_range(0, 200) - 100);
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      junk = '0;
    end
    return {junk[31:8], lo};
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Result side: random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each returned item with the oldest expectation.
  always @(posedge clk) begin : result_check
    pixel_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pix_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = pix_expected.pop_front();
        check_channel("out_red", out_data.out_red, want.out_red);
        check_channel("out_green", out_data.out_green, want.out_green);
        check_channel("out_blue", out_data.out_blue, want.out_blue);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    pixel_in_t px;
    // Pass-through straight after reset.
    add_known(0, 0, 0, 0, 0, 0);
    add_known(255, 255, 255, 255, 255, 255);
    add_known(8'h55, 8'hAA, 8'h0F, 8'h55, 8'hAA, 8'h0F);
    // Each preset filter in turn.
    add_write(REG_FILTER_MODE, 32'(FILT_NEGATIVE));
    add_known(0, 255, 8'h5A, 255, 0, 8'hA5);
    add_write(REG_FILTER_MODE, 32'(FILT_GRAY));
    add_known(255, 255, 255, 255, 255, 255);
    add_pixel(10, 20, 30);
    add_write(REG_FILTER_MODE, 32'(FILT_SEPIA));
    add_known(255, 255, 255, 255, 255, 238);
    add_pixel(100, 50, 20);
    add_write(REG_FILTER_MODE, 32'(FILT_PASTEL));
    add_known(0, 0, 0, 70, 60, 95);
    add_known(255, 255, 255, 255, 255, 255);
    add_write(REG_FILTER_MODE, 32'(FILT_VINTAGE));
    add_known(0, 0, 0, 127, 127, 127);
    add_known(255, 255, 255, 255, 255, 255);
    add_pixel(200, 100, 50);
    // Spare filter codes leave the pixel alone.
    add_write(REG_FILTER_MODE, 32'(FILT_SPARE));
    add_known(1, 2, 3, 1, 2, 3);
    add_write(REG_FILTER_MODE, 32'hFFFF_FFFF);
    add_known(200, 100, 50, 200, 100, 50);
    // Bits above the mode field are dropped, leaving grey.
    add_write(REG_FILTER_MODE, 32'h0000_0F09);
    add_pixel(30, 60, 90);
    add_write(REG_FILTER_MODE, 32'(FILT_NONE));
    // Out-of-range brightness saturates to +100 and -100.
    add_write(REG_BRIGHTNESS, 32'h0000_007F);
    add_known(200, 0, 50, 255, 100, 150);
    add_write(REG_BRIGHTNESS, 32'hABCD_EF80);
    add_known(50, 255, 150, 0, 155, 50);
    add_write(REG_BRIGHTNESS, 32'd0);
    add_write(REG_CONTRAST, 32'h0000_0064);
    add_pixel(128, 0, 255);
    add_write(REG_CONTRAST, 32'h0000_009C);
    add_pixel(0, 255, 77);
    add_write(REG_CONTRAST, 32'd0);
    add_write(REG_TEMPERATURE, 32'h0000_0064);
    add_known(20, 7, 230, 50, 7, 200);
    add_known(255, 0, 0, 255, 0, 0);
    add_write(REG_TEMPERATURE, 32'h0000_009C);
    add_known(20, 7, 230, 0, 7, 255);
    add_write(REG_TEMPERATURE, 32'd0);
    add_write(REG_RED_GAIN, 32'h0000_0064);
    add_write(REG_GREEN_GAIN, 32'h0000_009C);
    add_write(REG_BLUE_GAIN, 32'h0000_0025);
    add_known(100, 100, 100, 200, 0, 137);
    add_known(255, 255, 255, 255, 0, 255);
    add_write(REG_RED_GAIN, 32'd0);
    add_write(REG_GREEN_GAIN, 32'd0);
    add_write(REG_BLUE_GAIN, 32'd0);
    // A write past the last register must change nothing.
    add_write(REG_UNUSED, 32'hFFFF_FFFF);
    add_known(9, 8, 7, 9, 8, 7);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    idle_pct = 25;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        wait_drained();
        write_reg(directed_rows[i].idx, directed_rows[i].wdata);
      end else begin
        send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases, each under fresh settings; phase 2 and the last one run without gaps.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      if (ph == 2 || ph == NUM_PHASES - 1) begin
        idle_pct = 0;
      end else begin
        idle_pct = ($urandom_range(0, 1) != 0) ? 40 : 15;
      end
      for (int r = 0; r <= REG_FILTER_MODE; r++) begin
        write_reg(REG_IDX_W'(r), pick_setting(ph, REG_IDX_W'(r)));
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_UNUSED, $urandom);
      end
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        px.in_red = rand_channel();
        px.in_green = rand_channel();
        px.in_blue = rand_channel();
        send_pixel(px, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pix_expected.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
